// ===== hw/rtl/pss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pss_pkg
// Shared constants and types for the positional sequence store.
// ----------------------------------------------------------------------------
package pss_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int POS_W    = 8;
  localparam int KIND_W   = 3;
  localparam int STAT_W   = 2;
  localparam int LEN_W    = 5;

  localparam logic [KIND_W-1:0] KIND_APPEND   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DUMP_FWD = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DUMP_REV = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
  localparam logic [STAT_W-1:0] ST_NONE = 2'd2;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_ROT_L,
    CELL_ROT_R
  } cell_op_t;

  // Broadcast from the sequencer to every cell.
  typedef struct packed {
    cell_op_t                  op;
    logic [IDX_W-1:0]          at;
    logic [CNT_W-1:0]          count;
    logic signed [DATA_W-1:0]  value;
    logic signed [DATA_W-1:0]  wrap;
  } cell_ctl_t;

endpackage

// ===== hw/rtl/pss_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pss_cell
// One list slot. Holds a value, or takes the value of a neighbor, the new value or the wrap value.
// ----------------------------------------------------------------------------
module pss_cell (
  input  logic                             clk,
  input  logic [pss_pkg::IDX_W-1:0]        idx,
  input  pss_pkg::cell_ctl_t               ctl,
  input  logic signed [pss_pkg::DATA_W-1:0] left,
  input  logic signed [pss_pkg::DATA_W-1:0] right,
  output logic signed [pss_pkg::DATA_W-1:0] q
);
  import pss_pkg::*;

  logic signed [DATA_W-1:0] q_next;
  logic [CNT_W-1:0]         pos;
  logic                     is_tail;

  assign pos     = CNT_W'(idx);
  assign is_tail = (pos + CNT_W'(1)) == ctl.count;

  always_comb begin
    q_next = q;
    unique case (ctl.op)
      CELL_INSERT: begin
        if (idx > ctl.at) begin
          q_next = left;
        end else if (idx == ctl.at) begin
          q_next = ctl.value;
        end
      end
      CELL_REMOVE: begin
        if (idx >= ctl.at) begin
          q_next = right;
        end
      end
      CELL_ROT_L: begin
        if (is_tail) begin
          q_next = ctl.wrap;
        end else if (pos < ctl.count) begin
          q_next = right;
        end
      end
      CELL_ROT_R: begin
        if (idx == '0) begin
          q_next = ctl.wrap;
        end else if (pos < ctl.count) begin
          q_next = left;
        end
      end
      default: q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

// ===== hw/rtl/pss_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pss_ctrl
// Request sequencer: element count, cell commands, dump walk, result register.
// ----------------------------------------------------------------------------
module pss_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [pss_pkg::KIND_W-1:0]        kind,
  input  logic signed [pss_pkg::DATA_W-1:0] value,
  input  logic [pss_pkg::POS_W-1:0]         position,
  input  logic signed [pss_pkg::DATA_W-1:0] head,
  input  logic signed [pss_pkg::DATA_W-1:0] tail,
  output pss_pkg::cell_ctl_t                ctl,
  output logic [pss_pkg::CNT_W-1:0]         count,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [pss_pkg::DATA_W-1:0] element,
  output logic [pss_pkg::STAT_W-1:0]        status,
  output logic                              last,
  output logic [pss_pkg::LEN_W-1:0]         length
);
  import pss_pkg::*;

  typedef enum logic {S_IDLE, S_DUMP} state_t;

  state_t           state;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] remain;
  logic             rev;
  logic             out_free;
  logic             take;
  logic             full;
  logic             rm_ok;
  logic             is_change;

  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE) || !out_free;
  assign take      = in_valid && !in_stall;
  assign full      = count == CNT_W'(CAPACITY);
  assign rm_ok     = POS_W'(count) > position;
  assign is_change = (kind == KIND_APPEND) || (kind == KIND_INSERT) || (kind == KIND_REMOVE);

  always_comb begin
    ctl.op     = CELL_HOLD;
    ctl.at     = '0;
    ctl.count  = count;
    ctl.value  = value;
    ctl.wrap   = rev ? tail : head;
    count_next = count;
    if (state == S_IDLE && take) begin
      unique case (kind)
        KIND_APPEND: begin
          if (!full) begin
            ctl.op     = CELL_INSERT;
            ctl.at     = count[IDX_W-1:0];
            count_next = count + CNT_W'(1);
          end
        end
        KIND_INSERT: begin
          if (!full) begin
            ctl.op     = CELL_INSERT;
            ctl.at     = (position >= POS_W'(count)) ? count[IDX_W-1:0]
                                                      : position[IDX_W-1:0];
            count_next = count + CNT_W'(1);
          end
        end
        KIND_REMOVE: begin
          if (rm_ok) begin
            ctl.op     = CELL_REMOVE;
            ctl.at     = position[IDX_W-1:0];
            count_next = count - CNT_W'(1);
          end
        end
        default: ctl.op = CELL_HOLD;
      endcase
    end else if (state == S_DUMP && out_free) begin
      ctl.op = rev ? CELL_ROT_R : CELL_ROT_L;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      remain    <= '0;
      rev       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (out_free) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (take) begin
            if (is_change) begin
              out_valid <= 1'b1;
              element   <= '0;
              last      <= 1'b1;
              length    <= LEN_W'(count_next);
              if (kind == KIND_REMOVE) begin
                status <= rm_ok ? ST_OK : ST_NONE;
              end else begin
                status <= full ? ST_FULL : ST_OK;
              end
            end else if (kind == KIND_DUMP_FWD || kind == KIND_DUMP_REV) begin
              rev <= (kind == KIND_DUMP_REV);
              if (count == '0) begin
                out_valid <= 1'b1;
                element   <= '0;
                status    <= ST_OK;
                last      <= 1'b1;
                length    <= '0;
              end else begin
                remain <= count;
                state  <= S_DUMP;
              end
            end
          end
        end
        S_DUMP: begin
          if (out_free) begin
            out_valid <= 1'b1;
            element   <= rev ? tail : head;
            status    <= ST_OK;
            last      <= (remain == CNT_W'(1));
            length    <= LEN_W'(count);
            remain    <= remain - CNT_W'(1);
            if (remain == CNT_W'(1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY)) else $error("element count above capacity");

  a_change_result: assert property (@(posedge clk) disable iff (rst)
    take && is_change |=> out_valid) else $error("change gave no result");

  a_dump_blocks: assert property (@(posedge clk) disable iff (rst)
    state == S_DUMP |-> in_stall) else $error("request taken during dump");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> last && element == '0)
    else $error("error status on a non-final result");

endmodule

// ===== hw/rtl/positional_sequence_store_unit.sv =====
`timescale 1ns / 1ps
// Changes and empty dumps register their result as the request is taken.
// Append, insert, remove: all cells shift together as the request is taken.
// Dump of N elements: the dump state gives one element per cycle while the
// result is not stalled (the cell row rotates once per element).
// Reset (rst, synchronous): list empty, no result pending; cell data is not cleared.
// ----------------------------------------------------------------------------
// positional_sequence_store_unit
// Bounded ordered list of signed 32-bit values held in a row of shifting cells.
// ----------------------------------------------------------------------------
module positional_sequence_store_unit (
  input  logic                              clk,
  input  logic                              rst,
  // request channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [pss_pkg::KIND_W-1:0]        kind,
  input  logic signed [pss_pkg::DATA_W-1:0] value,
  input  logic [pss_pkg::POS_W-1:0]         position,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [pss_pkg::DATA_W-1:0] element,
  output logic [pss_pkg::STAT_W-1:0]        status,
  output logic                              last,
  output logic [pss_pkg::LEN_W-1:0]         length
);
  import pss_pkg::*;

  // Cell contents, front of the list in cell 0.
  logic signed [DATA_W-1:0] q [CAPACITY];
  cell_ctl_t                ctl;
  logic [CNT_W-1:0]         count;
  logic signed [DATA_W-1:0] head;
  logic signed [DATA_W-1:0] tail;
  logic [IDX_W-1:0]         tail_idx;

  // Tail is only looked at while the list is non-empty.
  assign tail_idx = IDX_W'(count - CNT_W'(1));
  assign head     = q[0];
  assign tail     = q[tail_idx];

  pss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .value     (value),
    .position  (position),
    .head      (head),
    .tail      (tail),
    .ctl       (ctl),
    .count     (count),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .element   (element),
    .status    (status),
    .last      (last),
    .length    (length)
  );

  // Insert shifts toward the back (take left), remove and forward rotation
  // shift toward the front (take right). End cells see themselves.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left;
    logic signed [DATA_W-1:0] right;

    if (i == 0) begin : g_first
      assign left = q[i];
    end else begin : g_mid_l
      assign left = q[i-1];
    end

    if (i == CAPACITY - 1) begin : g_final
      assign right = q[i];
    end else begin : g_mid_r
      assign right = q[i+1];
    end

    pss_cell u_cell (
      .clk   (clk),
      .idx   (IDX_W'(i)),
      .ctl   (ctl),
      .left  (left),
      .right (right),
      .q     (q[i])
    );
  end

endmodule

// ===== dv/positional_sequence_store_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_sequence_store_unit_tb
// Self-checking bench for the bounded list: directed corner requests, then a
// random run that fills and drains the list while both channels idle at random.
// ----------------------------------------------------------------------------
module positional_sequence_store_unit_tb;
  import pss_pkg::*;

  // Kinds past the last real operation; the block must drop them silently.
  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

  localparam int RANDOM_REQUESTS = 135;
  localparam int WATCHDOG_LIMIT  = 2000;
  // A dump of a full list is the longest tail a request can leave behind.
  localparam int DRAIN_CYCLES    = 2 * CAPACITY + 4;

  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_t;

  // One result as the block should present it.
  typedef struct {
    logic signed [DATA_W-1:0] element;
    logic [STAT_W-1:0]        status;
    logic                     last;
    logic [LEN_W-1:0]         length;
  } list_result_t;

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_stall;
  logic [KIND_W-1:0]        kind;
  logic signed [DATA_W-1:0] value;
  logic [POS_W-1:0]         position;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [DATA_W-1:0] element;
  logic [STAT_W-1:0]        status;
  logic                     last;
  logic [LEN_W-1:0]         length;

  // Bench copy of the list, updated as each request is accepted.
  logic signed [DATA_W-1:0] list_mem [CAPACITY];
  int unsigned              list_len;
  list_result_t             pending_list_results [$];

  int          mismatch_count;
  int          burst_left;
  int          idle_cycles;
  stall_mode_t stall_mode;
  int          stall_phase_left;

  positional_sequence_store_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .value     (value),
    .position  (position),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .element   (element),
    .status    (status),
    .last      (last),
    .length    (length)
  );

  always #4 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor: applies one accepted request to the bench list and queues the
  // results the block owes for it. Changes give one status result; dumps give
  // one result per element, or a single zero-length result when empty.
  // --------------------------------------------------------------------------
  task automatic apply_list_request(input logic [KIND_W-1:0] k,
                                    input logic signed [DATA_W-1:0] v,
                                    input logic [POS_W-1:0] p);
    int unsigned  at;
    int unsigned  i;
    list_result_t r;
    r.element = '0;
    r.status  = ST_OK;
    r.last    = 1'b1;
    case (k)
      KIND_APPEND, KIND_INSERT: begin
        if (list_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          // insert clamps its index to the end; append always lands there
          at = (k == KIND_APPEND || p > list_len) ? list_len : p;
          for (i = list_len; i > at; i--) list_mem[i] = list_mem[i-1];
          list_mem[at] = v;
          list_len++;
        end
        r.length = list_len[LEN_W-1:0];
        pending_list_results.push_back(r);
      end
      KIND_REMOVE: begin
        if (p >= list_len) begin
          r.status = ST_NONE;
        end else begin
          for (i = p; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
        r.length = list_len[LEN_W-1:0];
        pending_list_results.push_back(r);
      end
      KIND_DUMP_FWD, KIND_DUMP_REV: begin
        r.length = list_len[LEN_W-1:0];
        if (list_len == 0) begin
          pending_list_results.push_back(r);
        end else begin
          for (i = 0; i < list_len; i++) begin
            r.element = (k == KIND_DUMP_FWD) ? list_mem[i] : list_mem[list_len-1-i];
            r.last    = (i + 1 == list_len);
            pending_list_results.push_back(r);
          end
        end
      end
      default: begin
        // spare kinds: no result, no change
      end
    endcase
  endtask

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("%0t ns  mismatch: %s", $time, what);
  endtask

  // --------------------------------------------------------------------------
  // Sender. Requests go out in bursts; between bursts valid drops for a random
  // pause. Some bursts are long so that back-to-back intake is exercised.
  // Called at a rising edge, returns at the edge where the request was taken.
  // --------------------------------------------------------------------------
  task automatic send_request(input logic [KIND_W-1:0] k,
                              input logic signed [DATA_W-1:0] v,
                              input logic [POS_W-1:0] p);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 8);
    end
    burst_left--;
    in_valid <= 1'b1;
    kind     <= k;
    value    <= v;
    position <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_list_request(k, v, p);
  endtask

  // Mostly random data, with the extremes mixed in often.
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 19))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return '0;
      3:       return -1;
      default: return $urandom;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: stall pattern that switches mode at random intervals, from
  // never stalling through light and heavy random stalls to strict toggling.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_phase_left == 0) begin
      stall_mode       <= stall_mode_t'($urandom_range(0, 3));
      stall_phase_left <= $urandom_range(16, 80);
    end else begin
      stall_phase_left <= stall_phase_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= ~out_stall;
    endcase
  end

  // --------------------------------------------------------------------------
  // Result checker: every accepted result against the oldest expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    list_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_list_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: element=%0d status=%0d",
                                  element, status));
      end else begin
        want = pending_list_results.pop_front();
        if (element !== want.element)
          report_mismatch($sformatf("element %0d, want %0d", element, want.element));
        if (status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", status, want.status));
        if (last !== want.last)
          report_mismatch($sformatf("last %0b, want %0b", last, want.last));
        if (length !== want.length)
          report_mismatch($sformatf("length %0d, want %0d", length, want.length));
      end
    end
  end

  // Watchdog: ends the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Dumps and a remove on an empty list.
  task automatic test_empty_list();
    send_request(KIND_DUMP_FWD, pick_value(), 8'd0);
    send_request(KIND_REMOVE, pick_value(), 8'd0);
    send_request(KIND_DUMP_REV, pick_value(), 8'd255);
  endtask

  // Fill to capacity through front, clamped and middle inserts, then try to
  // grow a full list both ways and dump it in both directions.
  task automatic test_fill_to_capacity();
    send_request(KIND_APPEND, VAL_MIN, 8'd0);
    send_request(KIND_APPEND, VAL_MAX, 8'd0);
    send_request(KIND_INSERT, -1, 8'd0);
    send_request(KIND_INSERT, '0, 8'd255);
    send_request(KIND_INSERT, 32'sh5555_5555, 8'd2);
    while (list_len < CAPACITY) send_request(KIND_APPEND, pick_value(), 8'($urandom));
    send_request(KIND_APPEND, pick_value(), 8'd0);
    send_request(KIND_INSERT, pick_value(), 8'd0);
    send_request(KIND_DUMP_FWD, '0, 8'd0);
    send_request(KIND_DUMP_REV, '0, 8'd0);
  endtask

  // Remove at the count, at the front, at the last index and far past the end.
  task automatic test_remove_edges();
    send_request(KIND_REMOVE, '0, 8'(list_len));
    send_request(KIND_REMOVE, '0, 8'd0);
    send_request(KIND_REMOVE, '0, 8'(list_len - 1));
    send_request(KIND_REMOVE, '0, 8'd255);
    send_request(KIND_DUMP_REV, '0, 8'd0);
  endtask

  // Spare kinds must be taken and dropped without a result.
  task automatic test_spare_kinds();
    logic [KIND_W-1:0] k;
    for (k = KIND_SPARE_LO; k <= KIND_SPARE_HI && k >= KIND_SPARE_LO; k++)
      send_request(k, pick_value(), 8'($urandom));
  endtask

  // Random traffic that sweeps the list between empty and full. The growing
  // flag biases changes toward insert or remove; positions are mostly in
  // range, sometimes anywhere in 0..255.
  task automatic test_random_traffic();
    int                growing;
    int                sent;
    int                roll;
    logic [POS_W-1:0]  p;
    growing = 1;
    sent    = 0;
    while (sent < RANDOM_REQUESTS) begin
      if (list_len == 0) growing = 1;
      else if (list_len == CAPACITY && $urandom_range(0, 1)) growing = 0;
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        send_request(KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)),
                     pick_value(), 8'($urandom));
      end else begin
        sent++;
        if (roll < 13) begin
          send_request($urandom_range(0, 1) ? KIND_DUMP_FWD : KIND_DUMP_REV,
                       pick_value(), 8'($urandom));
        end else if (($urandom_range(0, 3) != 0) == (growing != 0)) begin
          p = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, list_len)) : 8'($urandom);
          send_request($urandom_range(0, 1) ? KIND_INSERT : KIND_APPEND, pick_value(), p);
        end else begin
          p = ($urandom_range(0, 6) != 0 && list_len != 0) ?
              8'($urandom_range(0, list_len - 1)) : 8'($urandom);
          send_request(KIND_REMOVE, pick_value(), p);
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    clk              = 1'b0;
    rst              = 1'b1;
    in_valid         = 1'b0;
    kind             = KIND_APPEND;
    value            = '0;
    position         = '0;
    out_stall        = 1'b0;
    stall_mode       = STALL_NONE;
    stall_phase_left = 0;
    idle_cycles      = 0;
    mismatch_count   = 0;
    burst_left       = 0;
    list_len         = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_list();
    test_fill_to_capacity();
    test_remove_edges();
    test_spare_kinds();
    test_random_traffic();

    in_valid <= 1'b0;
    while (pending_list_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
